// ----- design/psrc_pkg.sv -----
// ----------------------------------------------------------------------------
// psrc_pkg
// Shared sizes, codes, types and helpers of the power state residency counter.
// ----------------------------------------------------------------------------
`default_nettype none

package psrc_pkg;

    // Table sizes
    localparam int MAX_NODES   = 16;
    localparam int NUM_STATES  = 22;
    localparam int NUM_MODULES = 8;

    // Field widths
    localparam int ID_W     = 16;
    localparam int TS_W     = 31;
    localparam int CODE_W   = 5;
    localparam int STATUS_W = 3;
    localparam int EL_W     = 32;
    localparam int TOT_W    = 48;
    localparam int CFG_W    = 40;
    localparam int TYPE_W   = 2;
    localparam int MOD_W    = 3;

    // Node slot index and memory geometry
    localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NODE_RAM_W = ID_W + CODE_W;
    localparam int MOD_DEPTH  = MAX_NODES * NUM_MODULES;
    localparam int MOD_AW     = $clog2(MOD_DEPTH);
    localparam int MOD_RAM_W  = TS_W + CODE_W;
    localparam int TOT_DEPTH  = MAX_NODES * NUM_STATES;
    localparam int TOT_AW     = $clog2(TOT_DEPTH);

    // Register reset and saturation limits
    localparam logic [CFG_W-1:0] CFG_RESET = 40'd742542191875;
    localparam logic [TOT_W-1:0] TOT_MAX   = {1'b0, {(TOT_W-1){1'b1}}};
    localparam logic [TOT_W-1:0] TOT_MIN   = {1'b1, {(TOT_W-1){1'b0}}};

    // Request types
    localparam logic [TYPE_W-1:0] REQ_REGISTER = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_EVENT    = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_READ     = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_NONE     = 2'd3;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CODE  = 3'd4;

    // Lock states kept as last lock
    localparam logic [CODE_W-1:0] LOCK_FIRST  = 5'd6;
    localparam logic [CODE_W-1:0] LOCK_SECOND = 5'd7;

    // Outcome of one node table search
    typedef struct packed {
        logic              done;
        logic              found;
        logic [NODE_W-1:0] found_idx;
        logic              free_found;
        logic [NODE_W-1:0] free_idx;
        logic [CODE_W-1:0] lock;
    } scan_res_t;

    // Module that owns a state code
    function automatic logic [MOD_W-1:0] module_of(input logic [CODE_W-1:0] code);
        logic [MOD_W-1:0] m;
        if (code <= 5'd5)       m = 3'd0;
        else if (code <= 5'd8)  m = 3'd1;
        else if (code <= 5'd11) m = 3'd2;
        else if (code <= 5'd13) m = 3'd3;
        else if (code <= 5'd15) m = 3'd4;
        else if (code <= 5'd17) m = 3'd5;
        else if (code <= 5'd19) m = 3'd6;
        else                    m = 3'd7;
        return m;
    endfunction

    // Initial state of module k out of the configuration word
    function automatic logic [CODE_W-1:0] init_code(input logic [CFG_W-1:0] cfg,
                                                    input logic [MOD_W-1:0] k);
        logic [CODE_W-1:0] c;
        case (k)
            3'd0:    c = cfg[4:0];
            3'd1:    c = cfg[9:5];
            3'd2:    c = cfg[14:10];
            3'd3:    c = cfg[19:15];
            3'd4:    c = cfg[24:20];
            3'd5:    c = cfg[29:25];
            3'd6:    c = cfg[34:30];
            3'd7:    c = cfg[39:35];
            default: c = '0;
        endcase
        return c;
    endfunction

    // Row of (node, module) in the module memory
    function automatic logic [MOD_AW-1:0] mod_addr(input logic [NODE_W-1:0] idx,
                                                   input logic [MOD_W-1:0] m);
        return MOD_AW'(idx) * MOD_AW'(NUM_MODULES) + MOD_AW'(m);
    endfunction

    // Row of (node, state) in the totals memory
    function automatic logic [TOT_AW-1:0] tot_addr(input logic [NODE_W-1:0] idx,
                                                   input logic [CODE_W-1:0] st);
        return TOT_AW'(idx) * TOT_AW'(NUM_STATES) + TOT_AW'(st);
    endfunction

endpackage

`default_nettype wire

// ----- design/psrc_ram.sv -----
// ----------------------------------------------------------------------------
// psrc_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psrc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire              aclk,
    input  wire              we,
    input  wire [ADDR_W-1:0] waddr,
    input  wire [WIDTH-1:0]  wdata,
    input  wire              re,
    input  wire [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/psrc_node_table.sv -----
// ----------------------------------------------------------------------------
// psrc_node_table
// Node id table with valid bits; linear search for an id and the lowest free
// slot, one entry per cycle, and a write port for registration and lock state.
// ----------------------------------------------------------------------------
`default_nettype none

module psrc_node_table
    import psrc_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              scan_start,
    input  wire [ID_W-1:0]   scan_id,
    input  wire              wr_en,
    input  wire [NODE_W-1:0] wr_idx,
    input  wire [ID_W-1:0]   wr_id,
    input  wire [CODE_W-1:0] wr_lock,
    output scan_res_t        scan_res
);

    localparam logic [NODE_W:0]   SCAN_END = (NODE_W+1)'(MAX_NODES);
    localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(MAX_NODES - 1);

    logic [MAX_NODES-1:0]  valid_reg;
    logic                  busy_reg;
    logic [NODE_W:0]       cnt_reg;
    logic                  chk_valid_reg;
    logic [NODE_W-1:0]     chk_idx_reg;
    logic                  done_reg;
    logic                  found_reg;
    logic [NODE_W-1:0]     found_idx_reg;
    logic                  free_found_reg;
    logic [NODE_W-1:0]     free_idx_reg;
    logic [CODE_W-1:0]     lock_reg;

    logic                  rd_en;
    logic [NODE_RAM_W-1:0] rd_data;
    logic                  hit;

    // Issue one read per cycle while the count is short of the table size
    assign rd_en = busy_reg && (cnt_reg < SCAN_END) && !scan_start;
    assign hit   = valid_reg[chk_idx_reg] && (rd_data[NODE_RAM_W-1:CODE_W] == scan_id);

    psrc_ram #(
        .WIDTH  (NODE_RAM_W),
        .DEPTH  (MAX_NODES),
        .ADDR_W (NODE_W)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata ({wr_id, wr_lock}),
        .re    (rd_en),
        .raddr (cnt_reg[NODE_W-1:0]),
        .rdata (rd_data)
    );

    // Search sequencer: compare one entry behind the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            busy_reg       <= 1'b0;
            cnt_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (scan_start) begin
                busy_reg       <= 1'b1;
                cnt_reg        <= '0;
                chk_valid_reg  <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                chk_valid_reg <= rd_en;
                if (rd_en) begin
                    cnt_reg     <= cnt_reg + 1'b1;
                    chk_idx_reg <= cnt_reg[NODE_W-1:0];
                end
                if (chk_valid_reg) begin
                    if (hit && !found_reg) begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= chk_idx_reg;
                        lock_reg      <= rd_data[CODE_W-1:0];
                    end
                    if (!valid_reg[chk_idx_reg] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= chk_idx_reg;
                    end
                    if (chk_idx_reg == LAST_IDX) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign scan_res.done       = done_reg;
    assign scan_res.found      = found_reg;
    assign scan_res.found_idx  = found_idx_reg;
    assign scan_res.free_found = free_found_reg;
    assign scan_res.free_idx   = free_idx_reg;
    assign scan_res.lock       = lock_reg;

    // Valid bits only ever gain entries between resets
    a_valid_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ($countones(valid_reg) >= $past($countones(valid_reg))))
        else $error("node valid bit lost");

    // A search never reports completion while a new one is being started
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_start |=> !done_reg)
        else $error("search done straight after start");

endmodule

`default_nettype wire

// ----- design/power_state_residency_counter_top.sv -----
// ----------------------------------------------------------------------------
// power_state_residency_counter_top
// Per-node residency time in 22 power states over 8 modules, kept in RAM.
//
//   channel   ports                    dir   word
//   s_        valid/ready + 4 fields   in    request: type, node, time, state
//   m_        valid/ready + 5 fields   out   result: status and totals
//   cfg_      wr_en + wr_data          in    initial module states, 40 bits
//
// One request at a time. Each request but type none searches the node table
// one entry per cycle. Registration then clears 22 totals, one per cycle.
// Events read the module row, then, if the previous state is in range, read
// the total and write it back. Reads fetch one total.
// Reset is synchronous, active low; the memories need no clearing pass.
// A result waiting on m_ready stalls the sequencer in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module power_state_residency_counter_top
    import psrc_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    // configuration
    input  wire                     cfg_wr_en,
    input  wire [CFG_W-1:0]         cfg_wr_data,
    // request words
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire [TYPE_W-1:0]        s_req_type,
    input  wire [ID_W-1:0]          s_node_id,
    input  wire [TS_W-1:0]          s_timestamp,
    input  wire [CODE_W-1:0]        s_state_code,
    // result words
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [STATUS_W-1:0]     m_status,
    output logic [CODE_W-1:0]       m_charged_state,
    output logic signed [EL_W-1:0]  m_elapsed,
    output logic signed [TOT_W-1:0] m_residency_total,
    output logic [CODE_W-1:0]       m_last_lock_state
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_EV_MOD = 3'd4;
    localparam logic [2:0] S_EV_TOT = 3'd5;
    localparam logic [2:0] S_RD_TOT = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    localparam logic [CODE_W-1:0] CLR_LAST  = CODE_W'(NUM_STATES - 1);
    localparam logic [CODE_W-1:0] CODE_LIM  = CODE_W'(NUM_STATES);
    localparam logic [CODE_W-1:0] MOD_COUNT = CODE_W'(NUM_MODULES);

    logic [2:0]          state_reg, state_next;
    logic [CFG_W-1:0]    cfg_reg;
    logic [TYPE_W-1:0]   req_type_reg, req_type_next;
    logic [ID_W-1:0]     req_id_reg, req_id_next;
    logic [TS_W-1:0]     req_ts_reg, req_ts_next;
    logic [CODE_W-1:0]   req_code_reg, req_code_next;
    logic [CODE_W-1:0]   clr_cnt_reg, clr_cnt_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [CODE_W-1:0]   res_charged_reg, res_charged_next;
    logic [EL_W-1:0]     res_elapsed_reg, res_elapsed_next;
    logic [TOT_W-1:0]    res_total_reg, res_total_next;
    logic [CODE_W-1:0]   res_lock_reg, res_lock_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [CODE_W-1:0]   m_charged_reg, m_charged_next;
    logic [EL_W-1:0]     m_elapsed_reg, m_elapsed_next;
    logic [TOT_W-1:0]    m_total_reg, m_total_next;
    logic [CODE_W-1:0]   m_lock_reg, m_lock_next;

    // node table
    scan_res_t           scan_res;
    logic                scan_start;
    logic                node_we;
    logic [NODE_W-1:0]   node_widx;
    logic [CODE_W-1:0]   node_wlock;

    // module memory: previous time and state per (node, module)
    logic                mod_we, mod_re;
    logic [MOD_AW-1:0]   mod_waddr, mod_raddr;
    logic [MOD_RAM_W-1:0] mod_wdata, mod_rdata;

    // totals memory: one 48-bit total per (node, state)
    logic                tot_we, tot_re;
    logic [TOT_AW-1:0]   tot_waddr, tot_raddr;
    logic [TOT_W-1:0]    tot_wdata, tot_rdata;

    logic                accept;
    logic [CODE_W-1:0]   prev_state;
    logic [TS_W-1:0]     prev_time;
    logic [EL_W-1:0]     elapsed;
    logic [TOT_W:0]      sum_wide;
    logic [TOT_W-1:0]    sum_sat;
    logic [MOD_W-1:0]    req_mod;

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign scan_start = accept && (s_req_type != REQ_NONE);

    assign prev_time  = mod_rdata[MOD_RAM_W-1:CODE_W];
    assign prev_state = mod_rdata[CODE_W-1:0];
    assign elapsed    = {1'b0, req_ts_reg} - {1'b0, prev_time};
    assign req_mod    = module_of(req_code_reg);

    // Charge the elapsed time, saturating to the signed 48-bit range
    assign sum_wide = {tot_rdata[TOT_W-1], tot_rdata}
                    + {{(TOT_W+1-EL_W){res_elapsed_reg[EL_W-1]}}, res_elapsed_reg};
    always_comb begin
        if (sum_wide[TOT_W] != sum_wide[TOT_W-1]) begin
            sum_sat = sum_wide[TOT_W] ? TOT_MIN : TOT_MAX;
        end else begin
            sum_sat = sum_wide[TOT_W-1:0];
        end
    end

    psrc_node_table u_node_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scan_start (scan_start),
        .scan_id    (req_id_next),
        .wr_en      (node_we),
        .wr_idx     (node_widx),
        .wr_id      (req_id_reg),
        .wr_lock    (node_wlock),
        .scan_res   (scan_res)
    );

    psrc_ram #(
        .WIDTH  (MOD_RAM_W),
        .DEPTH  (MOD_DEPTH),
        .ADDR_W (MOD_AW)
    ) u_mod_ram (
        .aclk  (aclk),
        .we    (mod_we),
        .waddr (mod_waddr),
        .wdata (mod_wdata),
        .re    (mod_re),
        .raddr (mod_raddr),
        .rdata (mod_rdata)
    );

    psrc_ram #(
        .WIDTH  (TOT_W),
        .DEPTH  (TOT_DEPTH),
        .ADDR_W (TOT_AW)
    ) u_tot_ram (
        .aclk  (aclk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .re    (tot_re),
        .raddr (tot_raddr),
        .rdata (tot_rdata)
    );

    // Sequencer and memory control
    always_comb begin
        state_next       = state_reg;
        req_type_next    = req_type_reg;
        req_id_next      = req_id_reg;
        req_ts_next      = req_ts_reg;
        req_code_next    = req_code_reg;
        clr_cnt_next     = clr_cnt_reg;
        res_status_next  = res_status_reg;
        res_charged_next = res_charged_reg;
        res_elapsed_next = res_elapsed_reg;
        res_total_next   = res_total_reg;
        res_lock_next    = res_lock_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_charged_next   = m_charged_reg;
        m_elapsed_next   = m_elapsed_reg;
        m_total_next     = m_total_reg;
        m_lock_next      = m_lock_reg;

        node_we    = 1'b0;
        node_widx  = scan_res.found_idx;
        node_wlock = '0;
        mod_we     = 1'b0;
        mod_waddr  = mod_addr(scan_res.found_idx, req_mod);
        mod_wdata  = {req_ts_reg, req_code_reg};
        mod_re     = 1'b0;
        mod_raddr  = mod_addr(scan_res.found_idx, req_mod);
        tot_we     = 1'b0;
        tot_waddr  = tot_addr(scan_res.found_idx, res_charged_reg);
        tot_wdata  = sum_sat;
        tot_re     = 1'b0;
        tot_raddr  = tot_addr(scan_res.found_idx, req_code_reg);

        // Drop the result word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_type_next    = s_req_type;
                    req_id_next      = s_node_id;
                    req_ts_next      = s_timestamp;
                    req_code_next    = s_state_code;
                    res_status_next  = ST_OK;
                    res_charged_next = '0;
                    res_elapsed_next = '0;
                    res_total_next   = '0;
                    res_lock_next    = '0;
                    state_next       = scan_start ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (req_type_reg == REQ_REGISTER) begin
                    if (scan_res.found) begin
                        res_status_next = ST_DUPLICATE;
                        state_next      = S_FIN;
                    end else if (!scan_res.free_found) begin
                        res_status_next = ST_FULL;
                        state_next      = S_FIN;
                    end else begin
                        node_we      = 1'b1;
                        node_widx    = scan_res.free_idx;
                        clr_cnt_next = '0;
                        state_next   = S_CLEAR;
                    end
                end else if (!scan_res.found) begin
                    res_status_next = ST_UNKNOWN;
                    state_next      = S_FIN;
                end else if (req_code_reg >= CODE_LIM) begin
                    res_status_next = ST_BAD_CODE;
                    state_next      = S_FIN;
                end else if (req_type_reg == REQ_READ) begin
                    tot_re     = 1'b1;
                    state_next = S_RD_TOT;
                end else begin
                    mod_re     = 1'b1;
                    state_next = S_EV_MOD;
                end
            end
            S_CLEAR: begin
                // Zero one total per cycle, seed the module rows alongside
                tot_we    = 1'b1;
                tot_waddr = tot_addr(scan_res.free_idx, clr_cnt_reg);
                tot_wdata = '0;
                if (clr_cnt_reg < MOD_COUNT) begin
                    mod_we    = 1'b1;
                    mod_waddr = mod_addr(scan_res.free_idx, clr_cnt_reg[MOD_W-1:0]);
                    mod_wdata = {req_ts_reg, init_code(cfg_reg, clr_cnt_reg[MOD_W-1:0])};
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = S_FIN;
                end
            end
            S_EV_MOD: begin
                // Store the new time and state; note a lock state
                mod_we           = 1'b1;
                res_elapsed_next = elapsed;
                if (req_code_reg == LOCK_FIRST || req_code_reg == LOCK_SECOND) begin
                    node_we       = 1'b1;
                    node_wlock    = req_code_reg;
                    res_lock_next = req_code_reg;
                end else begin
                    res_lock_next = scan_res.lock;
                end
                if (prev_state < CODE_LIM) begin
                    tot_re           = 1'b1;
                    tot_raddr        = tot_addr(scan_res.found_idx, prev_state);
                    res_charged_next = prev_state;
                    state_next       = S_EV_TOT;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_EV_TOT: begin
                tot_we         = 1'b1;
                res_total_next = sum_sat;
                state_next     = S_FIN;
            end
            S_RD_TOT: begin
                res_charged_next = req_code_reg;
                res_total_next   = tot_rdata;
                res_lock_next    = scan_res.lock;
                state_next       = S_FIN;
            end
            S_FIN: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_charged_next = res_charged_reg;
                    m_elapsed_next = res_elapsed_reg;
                    m_total_next   = res_total_reg;
                    m_lock_next    = res_lock_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            cfg_reg     <= CFG_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_type_reg    <= req_type_next;
        req_id_reg      <= req_id_next;
        req_ts_reg      <= req_ts_next;
        req_code_reg    <= req_code_next;
        clr_cnt_reg     <= clr_cnt_next;
        res_status_reg  <= res_status_next;
        res_charged_reg <= res_charged_next;
        res_elapsed_reg <= res_elapsed_next;
        res_total_reg   <= res_total_next;
        res_lock_reg    <= res_lock_next;
        m_status_reg    <= m_status_next;
        m_charged_reg   <= m_charged_next;
        m_elapsed_reg   <= m_elapsed_next;
        m_total_reg     <= m_total_next;
        m_lock_reg      <= m_lock_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_charged_state   = m_charged_reg;
    assign m_elapsed         = m_elapsed_reg;
    assign m_residency_total = m_total_reg;
    assign m_last_lock_state = m_lock_reg;

    // An error word carries nothing but its status
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |->
        (m_charged_state == '0 && m_elapsed == '0 && m_residency_total == '0
         && m_last_lock_state == '0))
        else $error("error word with payload");

    // Last lock state is either unset or one of the two lock states
    a_lock_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_lock_state == '0 || m_last_lock_state == LOCK_FIRST
                     || m_last_lock_state == LOCK_SECOND))
        else $error("bad last lock state");

    // Charged state always names a real state
    a_charged_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_charged_state < CODE_LIM))
        else $error("charged state out of range");

    // Totals are only written while clearing or charging
    a_tot_write: assert property (@(posedge aclk) disable iff (!aresetn)
        tot_we |-> (state_reg == S_CLEAR || state_reg == S_EV_TOT))
        else $error("stray totals write");

endmodule

`default_nettype wire
